// ----- hw/rtl/bsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap stream compaction package
// Beat types, lane constants and the compaction result bundle shared by the
// compaction datapath and the top level.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int LANES     = 8;
  localparam int ELEM_W    = 32;   // width of an element field on the ports
  localparam int ELEM_BITS = 32;   // element bits kept from each lane
  localparam int COUNT_W   = 4;    // lanes_valid and fill_count width
  localparam int STAGE_W   = 3;    // staged element count width
  localparam int TOTAL_W   = 32;
  localparam int QDEPTH    = 4;    // result queue depth in beats

  localparam logic [ELEM_W-1:0] ELEM_MASK =
      (ELEM_BITS >= ELEM_W) ? {ELEM_W{1'b1}}
                            : ELEM_W'((64'd1 << ELEM_BITS) - 64'd1);

  typedef logic [LANES-1:0][ELEM_W-1:0] lanes_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  elem_0;
    logic [ELEM_W-1:0]  elem_1;
    logic [ELEM_W-1:0]  elem_2;
    logic [ELEM_W-1:0]  elem_3;
    logic [ELEM_W-1:0]  elem_4;
    logic [ELEM_W-1:0]  elem_5;
    logic [ELEM_W-1:0]  elem_6;
    logic [ELEM_W-1:0]  elem_7;
    logic [LANES-1:0]   select_mask;
    logic [COUNT_W-1:0] lanes_valid;
    logic               stream_end;
  } item_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  packed_0;
    logic [ELEM_W-1:0]  packed_1;
    logic [ELEM_W-1:0]  packed_2;
    logic [ELEM_W-1:0]  packed_3;
    logic [ELEM_W-1:0]  packed_4;
    logic [ELEM_W-1:0]  packed_5;
    logic [ELEM_W-1:0]  packed_6;
    logic [ELEM_W-1:0]  packed_7;
    logic [COUNT_W-1:0] fill_count;
    logic               final_group;
    logic [TOTAL_W-1:0] total_selected;
  } result_t;

  // Everything one input beat produces: up to two results and the new state.
  typedef struct packed {
    logic               full_valid;
    logic               flush_valid;
    result_t            full_res;
    result_t            flush_res;
    lanes_t             staging_next;
    logic [STAGE_W-1:0] count_next;
    logic [TOTAL_W-1:0] total_next;
  } compact_t;

  function automatic result_t make_result(lanes_t lanes, logic [COUNT_W-1:0] fill,
                                          logic fin, logic [TOTAL_W-1:0] total);
    result_t r;
    r.packed_0       = lanes[0];
    r.packed_1       = lanes[1];
    r.packed_2       = lanes[2];
    r.packed_3       = lanes[3];
    r.packed_4       = lanes[4];
    r.packed_5       = lanes[5];
    r.packed_6       = lanes[6];
    r.packed_7       = lanes[7];
    r.fill_count     = fill;
    r.final_group    = fin;
    r.total_selected = total;
    return r;
  endfunction

endpackage

// ----- hw/rtl/bsc_compact.sv -----
// ----------------------------------------------------------------------------
// Bitmap stream compaction datapath
// Packs the selected lanes of one beat behind the staged elements and splits
// the result into a full group, a flush group and the next staging contents.
// ----------------------------------------------------------------------------
module bsc_compact (
  input  bsc_pkg::item_t                      item,
  input  bsc_pkg::lanes_t                     staging,
  input  logic [bsc_pkg::STAGE_W-1:0]         staged_count,
  input  logic [bsc_pkg::TOTAL_W-1:0]         selected_total,
  output bsc_pkg::compact_t                   comp
);

  logic [bsc_pkg::ELEM_W-1:0]  lane    [bsc_pkg::LANES];
  logic [bsc_pkg::ELEM_W-1:0]  fresh   [bsc_pkg::LANES];
  logic [bsc_pkg::ELEM_W-1:0]  comb_q  [2*bsc_pkg::LANES];
  logic [bsc_pkg::LANES-1:0]   keep;
  logic [bsc_pkg::STAGE_W-1:0] pos     [bsc_pkg::LANES];
  logic [bsc_pkg::COUNT_W-1:0] valid_n;
  logic [bsc_pkg::COUNT_W-1:0] n_fresh;
  logic [bsc_pkg::COUNT_W-1:0] sum;
  logic                        over;
  logic [bsc_pkg::STAGE_W-1:0] rem;
  logic [bsc_pkg::TOTAL_W:0]   total_wide;
  logic [bsc_pkg::TOTAL_W-1:0] total_sat;
  bsc_pkg::lanes_t             full_lanes;
  bsc_pkg::lanes_t             stage_lanes;
  bsc_pkg::lanes_t             flush_lanes;

  assign lane[0] = item.elem_0 & bsc_pkg::ELEM_MASK;
  assign lane[1] = item.elem_1 & bsc_pkg::ELEM_MASK;
  assign lane[2] = item.elem_2 & bsc_pkg::ELEM_MASK;
  assign lane[3] = item.elem_3 & bsc_pkg::ELEM_MASK;
  assign lane[4] = item.elem_4 & bsc_pkg::ELEM_MASK;
  assign lane[5] = item.elem_5 & bsc_pkg::ELEM_MASK;
  assign lane[6] = item.elem_6 & bsc_pkg::ELEM_MASK;
  assign lane[7] = item.elem_7 & bsc_pkg::ELEM_MASK;

  // Selected lanes and their packed positions from a running prefix count.
  always_comb begin
    logic [bsc_pkg::COUNT_W-1:0] acc;
    valid_n = (item.lanes_valid > bsc_pkg::COUNT_W'(bsc_pkg::LANES))
              ? bsc_pkg::COUNT_W'(bsc_pkg::LANES) : item.lanes_valid;
    acc = '0;
    for (int k = 0; k < bsc_pkg::LANES; k++) begin
      keep[k] = item.select_mask[k] && (bsc_pkg::COUNT_W'(k) < valid_n);
      pos[k]  = acc[bsc_pkg::STAGE_W-1:0];
      acc     = acc + bsc_pkg::COUNT_W'(keep[k]);
    end
    n_fresh = acc;
  end

  always_comb begin
    for (int j = 0; j < bsc_pkg::LANES; j++) begin
      fresh[j] = '0;
      for (int k = 0; k < bsc_pkg::LANES; k++) begin
        if (keep[k] && pos[k] == bsc_pkg::STAGE_W'(j)) fresh[j] = lane[k];
      end
    end
  end

  // Staged elements first, then the fresh ones; sixteen slots cover any mix.
  always_comb begin
    logic [4:0] idx;
    for (int i = 0; i < 2*bsc_pkg::LANES; i++) begin
      idx = 5'(i) - 5'(staged_count);
      if (5'(i) < 5'(staged_count)) begin
        comb_q[i] = staging[3'(i)];
      end else if (idx < 5'(bsc_pkg::LANES)) begin
        comb_q[i] = fresh[idx[2:0]];
      end else begin
        comb_q[i] = '0;
      end
    end
  end

  assign sum        = bsc_pkg::COUNT_W'(staged_count) + n_fresh;
  assign over       = sum[bsc_pkg::COUNT_W-1];
  assign rem        = sum[bsc_pkg::STAGE_W-1:0];
  assign total_wide = {1'b0, selected_total} + (bsc_pkg::TOTAL_W+1)'(n_fresh);
  assign total_sat  = total_wide[bsc_pkg::TOTAL_W] ? '1
                                                   : total_wide[bsc_pkg::TOTAL_W-1:0];

  always_comb begin
    for (int i = 0; i < bsc_pkg::LANES; i++) begin
      full_lanes[i]  = comb_q[i];
      stage_lanes[i] = over ? comb_q[i + bsc_pkg::LANES] : comb_q[i];
      flush_lanes[i] = (bsc_pkg::STAGE_W'(i) < rem) ? stage_lanes[i] : '0;
    end
  end

  always_comb begin
    comp.full_valid   = over;
    comp.flush_valid  = item.stream_end && (rem != '0 || !over);
    comp.full_res     = bsc_pkg::make_result(full_lanes, bsc_pkg::COUNT_W'(bsc_pkg::LANES),
                                             item.stream_end && rem == '0, total_sat);
    comp.flush_res    = bsc_pkg::make_result(flush_lanes, bsc_pkg::COUNT_W'(rem),
                                             1'b1, total_sat);
    comp.staging_next = stage_lanes;
    comp.count_next   = item.stream_end ? '0 : rem;
    comp.total_next   = item.stream_end ? '0 : total_sat;
  end

endmodule

// ----- hw/rtl/bitmap_stream_compaction_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap stream compaction core
// Filters eight-lane column blocks by a selection bitmap into packed groups.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes one block of eight elements per beat with its
//   selection bits, count of valid leading lanes and end-of-stream mark.
//   Selected elements are packed in order; every full group of eight leaves
//   on the result channel, and the final block flushes the remainder with
//   final_group set (an empty group if nothing remains, unless its full group takes it).
//   A block is registered at acceptance and compacted from the input register
//   into a four-beat result queue once the queue has room for two results.
//   One block per cycle is taken while the queue has room for two results;
//   a block yields at most two results, so the sustained rate is one block
//   per cycle whenever blocks average one result or fewer and the receiver does not stall.
//   When the receiver stalls, the queue fills and item_ready drops while a
//   block waits in the input register and the queue holds four results, or
//   holds three with none popped in that cycle; nothing is lost.
//   Synchronous reset empties the queue and clears the staged count and the
//   running total; staged elements need no reset.
// ----------------------------------------------------------------------------
module bitmap_stream_compaction_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  bsc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output bsc_pkg::result_t result
);

  bsc_pkg::item_t              item_q;
  logic                        item_q_valid;
  bsc_pkg::lanes_t             staging;
  logic [bsc_pkg::STAGE_W-1:0] staged_count;
  logic [bsc_pkg::TOTAL_W-1:0] selected_total;
  bsc_pkg::compact_t           comp;

  bsc_pkg::result_t q [bsc_pkg::QDEPTH];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       q_count;
  logic [1:0]       push_n;
  logic             pop;
  logic             advance;
  bsc_pkg::result_t first_res;

  bsc_compact u_compact (
    .item           (item_q),
    .staging        (staging),
    .staged_count   (staged_count),
    .selected_total (selected_total),
    .comp           (comp)
  );

  assign pop          = result_valid && result_ready;
  assign result_valid = (q_count != 3'd0);
  assign result       = q[rd_ptr];
  // Room for two results after this cycle's pop.
  assign advance      = item_q_valid && ((q_count <= 3'd2) || (q_count == 3'd3 && pop));
  assign item_ready   = !item_q_valid || advance;
  assign push_n       = advance ? (2'(comp.full_valid) + 2'(comp.flush_valid)) : 2'd0;
  assign first_res    = comp.full_valid ? comp.full_res : comp.flush_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
    if (item_ready && item_valid) item_q <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staged_count   <= '0;
      selected_total <= '0;
    end else if (advance) begin
      staged_count   <= comp.count_next;
      selected_total <= comp.total_next;
    end
    if (advance) staging <= comp.staging_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + push_n;
      rd_ptr  <= rd_ptr + 2'(pop);
      q_count <= q_count + 3'(push_n) - 3'(pop);
    end
    if (push_n != 2'd0) q[wr_ptr] <= first_res;
    if (push_n == 2'd2) q[wr_ptr + 2'd1] <= comp.flush_res;
  end

  assert property (@(posedge clk) disable iff (rst) q_count <= 3'(bsc_pkg::QDEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
      advance && item_q.stream_end |-> (comp.flush_valid || comp.full_res.final_group))
    else $error("final block produced no end-of-stream mark");

  assert property (@(posedge clk) disable iff (rst)
      advance && item_q.stream_end |=> (staged_count == '0 && selected_total == '0))
    else $error("stream state not cleared after final block");

  assert property (@(posedge clk) disable iff (rst)
      advance && comp.full_valid && comp.flush_valid |-> !comp.full_res.final_group)
    else $error("full group marked final ahead of a flush");

endmodule
